// ===== rtl/core/color_key_run_extractor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Color key run extractor: assertion macros
// Concurrent check wrappers. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_RUN_EXTRACTOR_UNIT_MACROS_SVH
`define COLOR_KEY_RUN_EXTRACTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define CKRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ckre: same-cycle check failed");
// Next-cycle implication
`define CKRE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ckre: next-cycle check failed");
`else
`define CKRE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CKRE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/ckre_pkg.sv =====
// ----------------------------------------------------------------------------
// Color key run extractor package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ckre_pkg;

  localparam int PIXEL_W      = 32;
  localparam int KEY_W        = 24;
  localparam int CFG_DIM_W    = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int RUN_LEFT_W   = 12;
  localparam int RUN_RIGHT_W  = 13;
  localparam int RUN_ROW_W    = 12;
  localparam int RUN_INDEX_W  = 23;

  localparam int MAX_DIMENSION_DEF = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  // Pixel formats
  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB888 = 1'b1;

  // Reset values
  localparam logic [KEY_W-1:0]     RST_COLOR_KEY    = 24'h000000;
  localparam logic                 RST_PIXEL_FORMAT = FMT_RGB888;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd4096;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;

  // Compare masks for the two formats
  localparam logic [KEY_W-1:0] MASK_RGB565 = 24'h00ffff;
  localparam logic [KEY_W-1:0] MASK_RGB888 = 24'hffffff;

  // Key pattern as seen by the compare stage
  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] mask;
  } key_cmp_t;

  // Compare stage to run tracker
  typedef struct packed {
    logic valid;
    logic is_key;
  } pix_stage_t;

  // Width of the clamped dimension datapath: holds both the register and the max
  function automatic int dim_width(input int max_dim);
    int bits;
    bits = $clog2(max_dim + 1);
    return (bits > CFG_DIM_W) ? bits : CFG_DIM_W;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ckre_pix_if.sv =====
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel word per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckre_pix_if
  import ckre_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckre_run_if.sv =====
// ----------------------------------------------------------------------------
// Run channel
// Valid/ready channel carrying one opaque run per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckre_run_if
  import ckre_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [RUN_LEFT_W-1:0]  run_left;
  logic [RUN_RIGHT_W-1:0] run_right;
  logic [RUN_ROW_W-1:0]   run_row;
  logic [RUN_INDEX_W-1:0] run_index;

  modport source (output valid, output run_left, output run_right, output run_row,
                  output run_index, input ready);
  modport sink   (input valid, input run_left, input run_right, input run_row,
                  input run_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckre_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckre_cfg_if
  import ckre_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckre_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four registers, derives the key pattern and clamped dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

module ckre_cfg_regs
  import ckre_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int DW = dim_width(MAX_DIMENSION)
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ckre_cfg_if.sink     cfg,
  output key_cmp_t     key_cmp,
  output logic [DW-1:0] width_eff,
  output logic [DW-1:0] height_eff
);

  localparam logic [DW-1:0] MAX_D = DW'(MAX_DIMENSION);
  localparam logic [DW-1:0] ONE_D = DW'(1);

  logic [KEY_W-1:0]     color_key_r;
  logic                 pixel_format_r;
  logic [CFG_DIM_W-1:0] image_width_r;
  logic [CFG_DIM_W-1:0] image_height_r;

  logic [7:0]    key_r8, key_g8, key_b8;
  logic [DW-1:0] w_ext, h_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_key_r    <= RST_COLOR_KEY;
      pixel_format_r <= RST_PIXEL_FORMAT;
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COLOR_KEY:    color_key_r    <= cfg.data[KEY_W-1:0];
        REG_PIXEL_FORMAT: pixel_format_r <= cfg.data[0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg.data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg.data[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Key arrives as 0x00BBGGRR
  assign key_r8 = color_key_r[7:0];
  assign key_g8 = color_key_r[15:8];
  assign key_b8 = color_key_r[23:16];

  always_comb begin
    if (pixel_format_r == FMT_RGB565) begin
      key_cmp.value = {8'h00, key_r8[7:3], key_g8[7:2], key_b8[7:3]};
      key_cmp.mask  = MASK_RGB565;
    end else begin
      key_cmp.value = {key_r8, key_g8, key_b8};
      key_cmp.mask  = MASK_RGB888;
    end
  end

  // Clamp to 1..MAX_DIMENSION
  assign w_ext = DW'(image_width_r);
  assign h_ext = DW'(image_height_r);

  always_comb begin
    if (w_ext == '0)        width_eff = ONE_D;
    else if (w_ext > MAX_D) width_eff = MAX_D;
    else                    width_eff = w_ext;
    if (h_ext == '0)        height_eff = ONE_D;
    else if (h_ext > MAX_D) height_eff = MAX_D;
    else                    height_eff = h_ext;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ckre_key_match.sv =====
// ----------------------------------------------------------------------------
// Key compare stage
// Accepts pixels, registers the key match flag for the run tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module ckre_key_match
  import ckre_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ckre_pix_if.sink   pix,
  input  key_cmp_t   key_cmp,
  input  wire logic  advance,
  output pix_stage_t stage
);

  logic valid_r, valid_nxt;
  logic is_key_r;
  logic accept;

  assign pix.ready = !valid_r || advance;
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept)       valid_nxt = 1'b1;
    else if (advance) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_key_r <= ((pix.pixel_color[KEY_W-1:0] ^ key_cmp.value) & key_cmp.mask) == '0;
    end
  end

  assign stage.valid  = valid_r;
  assign stage.is_key = is_key_r;

endmodule

`default_nettype wire

// ===== rtl/core/ckre_run_tracker.sv =====
// ----------------------------------------------------------------------------
// Run tracker
// Column/row counters, open-run state and the run output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ckre_run_tracker
  import ckre_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int DW    = dim_width(MAX_DIMENSION),
  localparam int CNT_W = $clog2(MAX_DIMENSION)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  pix_stage_t     stage,
  input  wire logic [DW-1:0] width_eff,
  input  wire logic [DW-1:0] height_eff,
  output logic           advance,
  ckre_run_if.source     run
);

  localparam logic [DW-1:0] ONE_D = DW'(1);

  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [CNT_W-1:0]       row_r, row_nxt;
  logic                   open_r, open_nxt;
  logic [CNT_W-1:0]       start_r, start_nxt;
  logic [RUN_INDEX_W-1:0] runs_r;

  logic                   out_valid_r;
  logic [RUN_LEFT_W-1:0]  out_left_r;
  logic [RUN_RIGHT_W-1:0] out_right_r;
  logic [RUN_ROW_W-1:0]   out_row_r;
  logic [RUN_INDEX_W-1:0] out_index_r;

  logic [DW-1:0] col_d, col_inc_d, row_inc_d, left_d, right_d, top_row_d;
  logic          line_end, frame_end, emit_key, emit, out_free;

  assign col_d     = DW'(col_r);
  assign col_inc_d = col_d + ONE_D;
  assign row_inc_d = DW'(row_r) + ONE_D;
  assign line_end  = col_inc_d >= width_eff;
  assign frame_end = row_inc_d >= height_eff;

  // A key pixel closes an open run; a line end closes any run that is open
  // after this pixel, which is exactly the non-key case.
  assign emit_key = open_r && stage.is_key;
  assign emit     = emit_key || (line_end && !stage.is_key);

  assign left_d    = (open_r) ? DW'(start_r) : col_d;
  assign right_d   = emit_key ? col_d : col_inc_d;
  assign top_row_d = height_eff - ONE_D - DW'(row_r);

  assign out_free = !out_valid_r || run.ready;
  assign advance  = stage.valid && (!emit || out_free);

  always_comb begin
    open_nxt  = !line_end && !stage.is_key;
    start_nxt = (!open_r && !stage.is_key) ? col_r : start_r;
    col_nxt   = line_end ? '0 : CNT_W'(col_inc_d);
    row_nxt   = row_r;
    if (line_end) row_nxt = frame_end ? '0 : CNT_W'(row_inc_d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      open_r      <= 1'b0;
      start_r     <= '0;
      runs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        open_r  <= open_nxt;
        start_r <= start_nxt;
        if (emit) runs_r <= runs_r + 1'b1;
      end
      if (advance && emit)  out_valid_r <= 1'b1;
      else if (run.ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_left_r  <= left_d[RUN_LEFT_W-1:0];
      out_right_r <= right_d[RUN_RIGHT_W-1:0];
      out_row_r   <= top_row_d[RUN_ROW_W-1:0];
      out_index_r <= runs_r;
    end
  end

  assign run.valid     = out_valid_r;
  assign run.run_left  = out_left_r;
  assign run.run_right = out_right_r;
  assign run.run_row   = out_row_r;
  assign run.run_index = out_index_r;

endmodule

`default_nettype wire

// ===== rtl/core/color_key_run_extractor_unit.sv =====
// Path: an accepted pixel goes through the compare register, then the run register, to its run, if any.
// Throughput: one pixel per cycle; the compare register and the run register each hold
//   one transaction, so pixels stall only while a finished run waits on out_run.ready.
// Reset: rst_n synchronous, active low; clears counters, open run, run numbering and
//   both valid flags, and loads the register defaults (key 0, 24-bit, 4096 x 4096).
// ----------------------------------------------------------------------------
// Color key run extractor
// Streams bottom-up bitmap pixels, compares each with a color key and emits
// one transaction per horizontal run of non-key pixels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_key_run_extractor_unit_macros.svh"

module color_key_run_extractor_unit
  import ckre_pkg::*;
#(
  // Largest usable width/height; sets the counter widths
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ckre_pix_if.sink   in_pix,
  ckre_run_if.source out_run,
  ckre_cfg_if.sink   cfg_wr
);

  localparam int DW = dim_width(MAX_DIMENSION);

  key_cmp_t      key_cmp;     // key value/mask for the active pixel format
  logic [DW-1:0] width_eff;   // image_width clamped to 1..MAX_DIMENSION
  logic [DW-1:0] height_eff;  // image_height clamped to 1..MAX_DIMENSION
  pix_stage_t    stage;       // registered compare result
  logic          advance;     // tracker consumes the registered pixel

  // Register file; config must only change while the pipeline is drained (the block does not enforce this)
  ckre_cfg_regs #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_wr),
    .key_cmp    (key_cmp),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  // Stage 1: input register holding only the valid bit and the key match flag
  ckre_key_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (in_pix),
    .key_cmp (key_cmp),
    .advance (advance),
    .stage   (stage)
  );

  // Stage 2: counters, run state and the run output register.
  // A pixel that closes no run moves on even while the output is stalled.
  ckre_run_tracker #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .advance    (advance),
    .run        (out_run)
  );

  // Input only backs up when a finished run is stuck in the output register
  `CKRE_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_pix.ready, out_run.valid && !out_run.ready)

  // Runs come out numbered consecutively
  `CKRE_ASSERT_NXT(a_index_seq, clk, rst_n, out_run.valid && out_run.ready, !out_run.valid || (out_run.run_index == RUN_INDEX_W'($past(out_run.run_index) + 1'b1)))

  // A run is never empty (left is exact when columns fit its field)
  `CKRE_ASSERT_IMP(a_run_nonempty, clk, rst_n, out_run.valid && (MAX_DIMENSION <= 4096), out_run.run_right > RUN_RIGHT_W'(out_run.run_left))

endmodule

`default_nettype wire
